// ----- rtl/core/sha1bh_pkg.sv -----
// Shared types, constants and control bundle for the SHA-1 block hasher.
package sha1bh_pkg;

  typedef logic [31:0] word_t;

  typedef struct packed {
    logic [31:0] message_word;
    logic        start_message;
    logic        end_message;
  } sha1bh_in_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  digest_index;
    logic        digest_last;
  } sha1bh_out_t;

  // Control strobes from the sequencer to the datapath.
  typedef struct packed {
    logic word_load;  // shift an accepted message word into the schedule
    logic iv_load;    // reload the chaining value with the initial value
    logic init;       // copy the chaining value into the working registers
    logic step;       // run one round and advance the schedule
    logic add;        // fold the working registers into the chaining value
  } sha1bh_ctl_t;

  localparam int ROUNDS      = 80;
  localparam int RND_W       = 7;
  localparam int DIGEST_LEN  = 5;
  localparam int IDX_W       = 3;
  localparam int BLOCK_WORDS = 16;
  localparam int POS_W       = 4;

  localparam logic [RND_W-1:0] RND_LAST = RND_W'(ROUNDS - 1);
  localparam logic [RND_W-1:0] RND_F1   = RND_W'(20);
  localparam logic [RND_W-1:0] RND_F2   = RND_W'(40);
  localparam logic [RND_W-1:0] RND_F3   = RND_W'(60);
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(DIGEST_LEN - 1);
  localparam logic [POS_W-1:0] POS_LAST = POS_W'(BLOCK_WORDS - 1);

  localparam word_t SHA1_IV [DIGEST_LEN] = '{
    32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
  };

  localparam word_t K_CH  = 32'h5a827999;
  localparam word_t K_P1  = 32'h6ed9eba1;
  localparam word_t K_MAJ = 32'h8f1bbcdc;
  localparam word_t K_P2  = 32'hca62c1d6;

endpackage

// ----- rtl/core/sha1_block_hasher.sv -----
// SHA-1 block hasher top level: word intake, round sequencer, digest output.
//
//   channel  | ports                      | handshake
//   ---------+----------------------------+-------------------------------
//   input    | start, busy, in_word       | word taken when start && !busy
//   result   | out_valid, out_word        | valid per word, no back-pressure
//
// A word that does not complete a block leaves busy low. The sixteenth word
// starts the block: ST_INIT loads a..e, 80 rounds run through the single round
// unit, ST_ADD adds into the chaining value, and ST_EMIT emits the five digest
// words on a final block; busy stays high until the return to ST_LOAD.
// Reset loads the initial chaining value and clears position and flags.
// The receiver cannot stall; digest words leave on consecutive cycles.
module sha1_block_hasher (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  output logic                    busy,
  input  sha1bh_pkg::sha1bh_in_t  in_word,
  output logic                    out_valid,
  output sha1bh_pkg::sha1bh_out_t out_word
);
  import sha1bh_pkg::*;

  typedef enum logic [4:0] {
    ST_LOAD  = 5'b00001,
    ST_INIT  = 5'b00010,
    ST_ROUND = 5'b00100,
    ST_ADD   = 5'b01000,
    ST_EMIT  = 5'b10000
  } state_t;

  state_t            state_r, state_nxt;
  logic [POS_W-1:0]  pos_r, pos_nxt;
  logic [RND_W-1:0]  rnd_r, rnd_nxt;
  logic [IDX_W-1:0]  idx_r, idx_nxt;
  logic              fp_r, fp_nxt;
  logic              accept;
  logic [POS_W-1:0]  pos_eff;
  logic              fp_eff;
  sha1bh_ctl_t       ctl;
  word_t             w_cur;
  word_t             chain [DIGEST_LEN];

  assign busy   = (state_r != ST_LOAD);
  assign accept = start && !busy;

  always_comb begin
    pos_eff = in_word.start_message ? '0 : pos_r;
    fp_eff  = (in_word.start_message ? 1'b0 : fp_r) | in_word.end_message;
  end

  always_comb begin
    state_nxt     = state_r;
    pos_nxt       = pos_r;
    rnd_nxt       = rnd_r;
    idx_nxt       = idx_r;
    fp_nxt        = fp_r;
    ctl           = '0;
    ctl.word_load = accept;
    ctl.iv_load   = accept && in_word.start_message;
    unique case (state_r)
      ST_LOAD: begin
        if (accept) begin
          fp_nxt  = fp_eff;
          pos_nxt = pos_eff + POS_W'(1);
          if (pos_eff == POS_LAST) begin
            state_nxt = ST_INIT;
          end
        end
      end
      ST_INIT: begin
        ctl.init  = 1'b1;
        rnd_nxt   = '0;
        state_nxt = ST_ROUND;
      end
      ST_ROUND: begin
        ctl.step = 1'b1;
        rnd_nxt  = rnd_r + RND_W'(1);
        if (rnd_r == RND_LAST) begin
          state_nxt = ST_ADD;
        end
      end
      ST_ADD: begin
        ctl.add = 1'b1;
        idx_nxt = '0;
        if (fp_r) begin
          fp_nxt    = 1'b0;
          state_nxt = ST_EMIT;
        end else begin
          state_nxt = ST_LOAD;
        end
      end
      ST_EMIT: begin
        idx_nxt = idx_r + IDX_W'(1);
        if (idx_r == IDX_LAST) begin
          state_nxt = ST_LOAD;
        end
      end
      default: state_nxt = ST_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_LOAD;
      pos_r   <= '0;
      rnd_r   <= '0;
      idx_r   <= '0;
      fp_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      pos_r   <= pos_nxt;
      rnd_r   <= rnd_nxt;
      idx_r   <= idx_nxt;
      fp_r    <= fp_nxt;
    end
  end

  sha1bh_sched u_sched (
    .clk     (clk),
    .ctl     (ctl),
    .word_in (in_word.message_word),
    .w_cur   (w_cur)
  );

  sha1bh_round u_round (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (ctl),
    .rnd   (rnd_r),
    .w_cur (w_cur),
    .chain (chain)
  );

  always_comb begin
    out_valid             = (state_r == ST_EMIT);
    out_word.digest_index = idx_r;
    out_word.digest_last  = (idx_r == IDX_LAST);
    case (idx_r)
      3'd0:    out_word.digest_word = chain[0];
      3'd1:    out_word.digest_word = chain[1];
      3'd2:    out_word.digest_word = chain[2];
      3'd3:    out_word.digest_word = chain[3];
      default: out_word.digest_word = chain[4];
    endcase
  end

endmodule

// ----- rtl/core/sha1bh_sched.sv -----
// Message schedule: 16-word shift line that gathers the block and expands it.
module sha1bh_sched (
  input  logic                clk,
  input  sha1bh_pkg::sha1bh_ctl_t ctl,
  input  sha1bh_pkg::word_t   word_in,
  output sha1bh_pkg::word_t   w_cur
);
  import sha1bh_pkg::*;

  word_t sched_r [BLOCK_WORDS];
  word_t mix;
  word_t expand;

  assign mix    = sched_r[13] ^ sched_r[8] ^ sched_r[2] ^ sched_r[0];
  assign expand = {mix[30:0], mix[31]};
  assign w_cur  = sched_r[0];

  always_ff @(posedge clk) begin
    if (ctl.word_load || ctl.step) begin
      for (int i = 0; i < BLOCK_WORDS - 1; i++) begin
        sched_r[i] <= sched_r[i+1];
      end
      sched_r[BLOCK_WORDS-1] <= ctl.word_load ? word_in : expand;
    end
  end

endmodule

// ----- rtl/core/sha1bh_round.sv -----
// Round unit: working registers a..e, one SHA-1 round per cycle, chaining value.
module sha1bh_round (
  input  logic                    clk,
  input  logic                    rst_n,
  input  sha1bh_pkg::sha1bh_ctl_t ctl,
  input  logic [sha1bh_pkg::RND_W-1:0] rnd,
  input  sha1bh_pkg::word_t       w_cur,
  output sha1bh_pkg::word_t       chain [sha1bh_pkg::DIGEST_LEN]
);
  import sha1bh_pkg::*;

  word_t a_r, b_r, c_r, d_r, e_r;
  word_t chain_r [DIGEST_LEN];
  word_t f;
  word_t k;
  word_t t;

  always_comb begin
    if (rnd < RND_F1) begin
      f = (b_r & c_r) | (~b_r & d_r);
      k = K_CH;
    end else if (rnd < RND_F2) begin
      f = b_r ^ c_r ^ d_r;
      k = K_P1;
    end else if (rnd < RND_F3) begin
      f = (b_r & c_r) | (b_r & d_r) | (c_r & d_r);
      k = K_MAJ;
    end else begin
      f = b_r ^ c_r ^ d_r;
      k = K_P2;
    end
    t = {a_r[26:0], a_r[31:27]} + f + e_r + w_cur + k;
  end

  always_ff @(posedge clk) begin
    if (ctl.init) begin
      a_r <= chain_r[0];
      b_r <= chain_r[1];
      c_r <= chain_r[2];
      d_r <= chain_r[3];
      e_r <= chain_r[4];
    end else if (ctl.step) begin
      a_r <= t;
      b_r <= a_r;
      c_r <= {b_r[1:0], b_r[31:2]};
      d_r <= c_r;
      e_r <= d_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || ctl.iv_load) begin
      chain_r <= SHA1_IV;
    end else if (ctl.add) begin
      chain_r[0] <= chain_r[0] + a_r;
      chain_r[1] <= chain_r[1] + b_r;
      chain_r[2] <= chain_r[2] + c_r;
      chain_r[3] <= chain_r[3] + d_r;
      chain_r[4] <= chain_r[4] + e_r;
    end
  end

  assign chain = chain_r;

endmodule
